### rtl/core/ihp_pkg.sv
`default_nettype none
package ihp_pkg;

    // field widths fixed by the interface
    localparam int VERTEX_BITS = 10;
    localparam int VERTEX_COUNT = 1024;
    localparam int OUT_KEY_BITS = 32;
    localparam int ENTRIES_BITS = 11;

    // commands
    localparam logic [1:0] CMD_LOAD     = 2'd0;
    localparam logic [1:0] CMD_BUILD    = 2'd1;
    localparam logic [1:0] CMD_DECREASE = 2'd2;
    localparam logic [1:0] CMD_EXTRACT  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef logic [VERTEX_BITS-1:0] t_vertex;

endpackage
`default_nettype wire

### rtl/core/indexed_min_heap.sv
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_stall   i_cmd, i_vertex, i_key
// out      output     o_out_valid / i_out_stall o_out_vertex, o_out_key, o_status, o_entries
//
// One transaction at a time. Load and failed commands go straight from lookup to finish.
// Per level, a sift up reads the parent, then compares; a sift down reads the left child,
// then the right child, then compares, as set by the single read port of the slot memory.
// Build costs one sift down per parent. After reset a clearing pass marks every vertex
// absent; input stalls meanwhile. A stalled result holds in the output register.
`default_nettype none
module indexed_min_heap #(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  [1:0]                          i_cmd,
    input  wire  [ihp_pkg::VERTEX_BITS-1:0]     i_vertex,
    input  wire  [31:0]                         i_key,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic [ihp_pkg::VERTEX_BITS-1:0]     o_out_vertex,
    output logic [ihp_pkg::OUT_KEY_BITS-1:0]    o_out_key,
    output logic [1:0]                          o_status,
    output logic [ihp_pkg::ENTRIES_BITS-1:0]    o_entries
);
    import ihp_pkg::*;

    localparam int SW = $clog2(CAPACITY);      // slot index
    localparam int CW = $clog2(CAPACITY + 1);  // count and map entry
    localparam int IW = SW + 2;                // child index before range check
    localparam int EW = VERTEX_BITS + KEY_BITS;
    localparam int VCW = $clog2(VERTEX_COUNT);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LOOK  = 4'd2;
    localparam logic [3:0] S_EX0   = 4'd3;
    localparam logic [3:0] S_EX1   = 4'd4;
    localparam logic [3:0] S_BNXT  = 4'd5;
    localparam logic [3:0] S_BLD   = 4'd6;
    localparam logic [3:0] S_DN    = 4'd7;
    localparam logic [3:0] S_DNL   = 4'd8;
    localparam logic [3:0] S_DNR   = 4'd9;
    localparam logic [3:0] S_DNC   = 4'd10;
    localparam logic [3:0] S_UP    = 4'd11;
    localparam logic [3:0] S_UPC   = 4'd12;
    localparam logic [3:0] S_PLACE = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;

    // memories: slot entry {vertex, key} and vertex-to-slot map
    logic [EW-1:0] heap_mem [CAPACITY];
    logic [CW-1:0] vslot_mem [VERTEX_COUNT];

    logic [3:0]          r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [VCW-1:0]      r_clr, n_clr;
    logic [1:0]          r_cmd, n_cmd;
    t_vertex             r_ev, n_ev;
    logic [KEY_BITS-1:0] r_ek, n_ek;
    logic [SW-1:0]       r_h, n_h;
    logic [CW-1:0]       r_bi, n_bi;
    logic                r_bsel, n_bsel;
    t_vertex             r_bv, n_bv;
    logic [KEY_BITS-1:0] r_bk, n_bk;
    logic [SW-1:0]       r_bidx, n_bidx;
    logic [1:0]          r_st, n_st;
    t_vertex             r_ov, n_ov;
    logic [KEY_BITS-1:0] r_ok, n_ok;

    logic                r_o_valid, n_o_valid;
    t_vertex             r_o_vertex, n_o_vertex;
    logic [OUT_KEY_BITS-1:0] r_o_key, n_o_key;
    logic [1:0]          r_o_status, n_o_status;
    logic [ENTRIES_BITS-1:0] r_o_entries, n_o_entries;

    logic [EW-1:0]       r_heap_rd;
    logic [CW-1:0]       r_vs_rd;

    logic                heap_we, vs_we;
    logic [SW-1:0]       heap_waddr, heap_raddr;
    logic [EW-1:0]       heap_wdata;
    t_vertex             vs_waddr, vs_raddr;
    logic [CW-1:0]       vs_wdata;

    logic [KEY_BITS-1:0] in_key, rd_key, cmp_key;
    t_vertex             rd_vertex;
    logic [IW-1:0]       idx_l, idx_r, idx_n;
    logic [SW-1:0]       last_slot, parent;
    logic [CW-1:0]       cnt_dec;
    logic                accept, present;

    // input key into KEY_BITS, zero filled
    always_comb begin
        in_key = '0;
        for (int b = 0; b < KEY_BITS && b < 32; b++) begin
            in_key[b] = i_key[b];
        end
    end

    assign rd_key    = r_heap_rd[KEY_BITS-1:0];
    assign rd_vertex = r_heap_rd[EW-1:KEY_BITS];
    assign idx_l     = (IW'(r_h) << 1) + IW'(1);
    assign idx_r     = idx_l + IW'(1);
    assign idx_n     = IW'(r_cnt);
    assign cnt_dec   = r_cnt - CW'(1);
    assign last_slot = cnt_dec[SW-1:0];
    assign parent    = (r_h - SW'(1)) >> 1;
    assign cmp_key   = r_bsel ? r_bk : r_ek;
    assign present   = r_vs_rd < r_cnt;
    assign accept    = i_in_valid && (r_state == S_IDLE);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_clr = r_clr;
        n_cmd = r_cmd;
        n_ev = r_ev;
        n_ek = r_ek;
        n_h = r_h;
        n_bi = r_bi;
        n_bsel = r_bsel;
        n_bv = r_bv;
        n_bk = r_bk;
        n_bidx = r_bidx;
        n_st = r_st;
        n_ov = r_ov;
        n_ok = r_ok;
        heap_we = 1'b0;
        heap_waddr = r_h;
        heap_wdata = {r_ev, r_ek};
        heap_raddr = '0;
        vs_we = 1'b0;
        vs_waddr = r_ev;
        vs_wdata = CW'(r_h);
        vs_raddr = i_vertex;

        unique case (r_state)
            S_CLR: begin
                vs_we = 1'b1;
                vs_waddr = r_clr;
                vs_wdata = '1;
                n_clr = r_clr + VCW'(1);
                if (r_clr == VCW'(VERTEX_COUNT - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    n_cmd = i_cmd;
                    n_ev = i_vertex;
                    n_ek = in_key;
                    n_st = ST_OK;
                    n_ov = '0;
                    n_ok = '0;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_FIN;
                unique case (r_cmd)
                    CMD_LOAD: begin
                        if (present) begin
                            heap_we = 1'b1;
                            heap_waddr = r_vs_rd[SW-1:0];
                        end else if (r_cnt >= CW'(CAPACITY)) begin
                            n_st = ST_FULL;
                        end else begin
                            heap_we = 1'b1;
                            heap_waddr = r_cnt[SW-1:0];
                            vs_we = 1'b1;
                            vs_wdata = r_cnt;
                            n_cnt = r_cnt + CW'(1);
                        end
                    end
                    CMD_BUILD: begin
                        if (r_cnt >= CW'(2)) begin
                            n_bi = r_cnt >> 1;
                            n_state = S_BNXT;
                        end
                    end
                    CMD_DECREASE: begin
                        if (!present) begin
                            n_st = ST_ABSENT;
                        end else begin
                            n_h = r_vs_rd[SW-1:0];
                            n_state = S_UP;
                        end
                    end
                    default: begin
                        if (r_cnt == '0) begin
                            n_st = ST_EMPTY;
                        end else begin
                            heap_raddr = '0;
                            n_state = S_EX0;
                        end
                    end
                endcase
            end
            S_EX0: begin
                n_ov = rd_vertex;
                n_ok = rd_key;
                vs_we = 1'b1;
                vs_waddr = rd_vertex;
                vs_wdata = '1;
                n_cnt = cnt_dec;
                if (r_cnt == CW'(1)) begin
                    n_state = S_FIN;
                end else begin
                    heap_raddr = last_slot;
                    n_state = S_EX1;
                end
            end
            S_EX1: begin
                n_ev = rd_vertex;
                n_ek = rd_key;
                n_h = '0;
                n_state = S_DN;
            end
            S_BNXT: begin
                if (r_bi == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_bi = r_bi - CW'(1);
                    heap_raddr = n_bi[SW-1:0];
                    n_h = n_bi[SW-1:0];
                    n_state = S_BLD;
                end
            end
            S_BLD: begin
                n_ev = rd_vertex;
                n_ek = rd_key;
                n_state = S_DN;
            end
            // sift down: hole at r_h, moving entry held in r_ev/r_ek
            S_DN: begin
                n_bsel = 1'b0;
                if (idx_l < idx_n) begin
                    heap_raddr = idx_l[SW-1:0];
                    n_state = S_DNL;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DNL: begin
                if (rd_key < r_ek) begin
                    n_bsel = 1'b1;
                    n_bk = rd_key;
                    n_bv = rd_vertex;
                    n_bidx = idx_l[SW-1:0];
                end
                if (idx_r < idx_n) begin
                    heap_raddr = idx_r[SW-1:0];
                    n_state = S_DNR;
                end else begin
                    n_state = S_DNC;
                end
            end
            S_DNR: begin
                if (rd_key < cmp_key) begin
                    n_bsel = 1'b1;
                    n_bk = rd_key;
                    n_bv = rd_vertex;
                    n_bidx = idx_r[SW-1:0];
                end
                n_state = S_DNC;
            end
            S_DNC: begin
                if (r_bsel) begin
                    heap_we = 1'b1;
                    heap_wdata = {r_bv, r_bk};
                    vs_we = 1'b1;
                    vs_waddr = r_bv;
                    n_h = r_bidx;
                    n_state = S_DN;
                end else begin
                    n_state = S_PLACE;
                end
            end
            // sift up
            S_UP: begin
                if (r_h == '0) begin
                    n_state = S_PLACE;
                end else begin
                    heap_raddr = parent;
                    n_state = S_UPC;
                end
            end
            S_UPC: begin
                if (r_ek < rd_key) begin
                    heap_we = 1'b1;
                    heap_wdata = r_heap_rd;
                    vs_we = 1'b1;
                    vs_waddr = rd_vertex;
                    n_h = parent;
                    n_state = S_UP;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                heap_we = 1'b1;
                vs_we = 1'b1;
                n_state = (r_cmd == CMD_BUILD) ? S_BNXT : S_FIN;
            end
            S_FIN: begin
                if (!r_o_valid || !i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register
    always_comb begin
        n_o_valid = r_o_valid && i_out_stall;
        n_o_vertex = r_o_vertex;
        n_o_key = r_o_key;
        n_o_status = r_o_status;
        n_o_entries = r_o_entries;
        if (r_state == S_FIN && (!r_o_valid || !i_out_stall)) begin
            n_o_valid = 1'b1;
            n_o_vertex = r_ov;
            n_o_status = r_st;
            n_o_key = '0;
            for (int b = 0; b < KEY_BITS && b < OUT_KEY_BITS; b++) begin
                n_o_key[b] = r_ok[b];
            end
            n_o_entries = '0;
            for (int b = 0; b < CW && b < ENTRIES_BITS; b++) begin
                n_o_entries[b] = r_cnt[b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt <= '0;
            r_clr <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_clr <= n_clr;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_ev <= n_ev;
        r_ek <= n_ek;
        r_h <= n_h;
        r_bi <= n_bi;
        r_bsel <= n_bsel;
        r_bv <= n_bv;
        r_bk <= n_bk;
        r_bidx <= n_bidx;
        r_st <= n_st;
        r_ov <= n_ov;
        r_ok <= n_ok;
        r_o_vertex <= n_o_vertex;
        r_o_key <= n_o_key;
        r_o_status <= n_o_status;
        r_o_entries <= n_o_entries;
    end

    // slot memory; a read of the entry being written returns its old contents
    always_ff @(posedge i_clk) begin
        if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
        r_heap_rd <= heap_mem[heap_raddr];
    end

    // vertex map memory
    always_ff @(posedge i_clk) begin
        if (vs_we) vslot_mem[vs_waddr] <= vs_wdata;
        r_vs_rd <= vslot_mem[vs_raddr];
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_o_valid;
    assign o_out_vertex = r_o_vertex;
    assign o_out_key    = r_o_key;
    assign o_status     = r_o_status;
    assign o_entries    = r_o_entries;

endmodule
`default_nettype wire

### rtl/core/ihp_check.sv
`default_nettype none
module ihp_check (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_stall,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [9:0]  o_out_vertex,
    input wire [31:0] o_out_key,
    input wire [1:0]  o_status,
    input wire [10:0] o_entries
);
    import ihp_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_vertex)
            && $stable(o_out_key) && $stable(o_status))
        else $error("stalled result changed");

    // an accepted transaction keeps the block busy the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken back to back");

    // only a successful extract returns a vertex and key
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_out_vertex == '0 && o_out_key == '0)
        else $error("payload on failed command");

    // empty status means nothing is stored
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_entries == '0)
        else $error("empty status with entries");

endmodule

bind indexed_min_heap ihp_check u_ihp_check (.*);
`default_nettype wire
